// File: sv/goldbach_prime_pair_finder_macros.svh
// ---------------------------------------------------------------------------
// goldbach prime pair finder assertion macros
// short forms for clocked implication checks, reset-qualified on arst_n
// ---------------------------------------------------------------------------
`ifndef GOLDBACH_PRIME_PAIR_FINDER_MACROS_SVH
`define GOLDBACH_PRIME_PAIR_FINDER_MACROS_SVH

// same-cycle implication
`define GPPF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPPF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/gppf_pkg.sv
// ---------------------------------------------------------------------------
// gppf_pkg
// sizes, microcode encoding and control store of the prime pair finder
// ---------------------------------------------------------------------------
`default_nettype none

package gppf_pkg;

	localparam int unsigned MAX_TARGET = 65536;
	localparam int unsigned FIELD_W    = 17;
	localparam int unsigned MAP_DEPTH  = MAX_TARGET + 1;
	localparam int unsigned ADDR_W     = $clog2(MAP_DEPTH);
	// counters carry one spare bit so that m + i and the next square never wrap
	localparam int unsigned WIDE_W     = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;
	localparam int unsigned PC_W       = 4;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [WIDE_W-1:0]  wide_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [PC_W-1:0]    pc_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT_WR,
		OP_SIEVE_SET,
		OP_RD_I,
		OP_M_SET,
		OP_MARK,
		OP_NEXT_I,
		OP_SCAN_SET,
		OP_RD_PAIR,
		OP_P_INC,
		OP_EMIT_HIT,
		OP_EMIT_MISS
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_N_BIG,
		C_IDX_LT_N,
		C_SQ_GT_N,
		C_NOT_PRIME,
		C_M_LE_N,
		C_P_GT_HALF,
		C_BOTH_PRIME
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// step addresses
	localparam pc_t ST_IDLE     = 4'd0;
	localparam pc_t ST_RANGE    = 4'd1;
	localparam pc_t ST_INIT     = 4'd2;
	localparam pc_t ST_SV_SET   = 4'd3;
	localparam pc_t ST_SV_TEST  = 4'd4;
	localparam pc_t ST_SV_CHK   = 4'd5;
	localparam pc_t ST_SV_MARK  = 4'd6;
	localparam pc_t ST_SV_NEXT  = 4'd7;
	localparam pc_t ST_SC_SET   = 4'd8;
	localparam pc_t ST_SC_RD    = 4'd9;
	localparam pc_t ST_SC_CHK   = 4'd10;
	localparam pc_t ST_SC_INC   = 4'd11;
	localparam pc_t ST_HIT      = 4'd12;
	localparam pc_t ST_MISS     = 4'd13;

	// control store: jump to target when the condition holds, else fall through
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			ST_IDLE:    w = '{op: OP_LOAD,      cond: C_NO_START,   target: ST_IDLE};
			ST_RANGE:   w = '{op: OP_NOP,       cond: C_N_BIG,      target: ST_MISS};
			ST_INIT:    w = '{op: OP_INIT_WR,   cond: C_IDX_LT_N,   target: ST_INIT};
			ST_SV_SET:  w = '{op: OP_SIEVE_SET, cond: C_NEVER,      target: ST_IDLE};
			ST_SV_TEST: w = '{op: OP_RD_I,      cond: C_SQ_GT_N,    target: ST_SC_SET};
			ST_SV_CHK:  w = '{op: OP_M_SET,     cond: C_NOT_PRIME,  target: ST_SV_NEXT};
			ST_SV_MARK: w = '{op: OP_MARK,      cond: C_M_LE_N,     target: ST_SV_MARK};
			ST_SV_NEXT: w = '{op: OP_NEXT_I,    cond: C_ALWAYS,     target: ST_SV_TEST};
			ST_SC_SET:  w = '{op: OP_SCAN_SET,  cond: C_NEVER,      target: ST_IDLE};
			ST_SC_RD:   w = '{op: OP_RD_PAIR,   cond: C_P_GT_HALF,  target: ST_MISS};
			ST_SC_CHK:  w = '{op: OP_NOP,       cond: C_BOTH_PRIME, target: ST_HIT};
			ST_SC_INC:  w = '{op: OP_P_INC,     cond: C_ALWAYS,     target: ST_SC_RD};
			ST_HIT:     w = '{op: OP_EMIT_HIT,  cond: C_ALWAYS,     target: ST_IDLE};
			ST_MISS:    w = '{op: OP_EMIT_MISS, cond: C_ALWAYS,     target: ST_IDLE};
			default:    w = '{op: OP_NOP,       cond: C_ALWAYS,     target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: sv/goldbach_prime_pair_finder.sv
// a target above MAX_TARGET skips the sieve and reports a miss; the result strobe
//   comes in the same cycle in which busy falls
// sieve: tests each base i with i*i <= n and clears the multiples of a prime i;
//   the bitmap has one write port and two read ports
// throughput: one transaction at a time, next start taken in the strobe cycle; no stall
// reset clears the step counter and strobe; the bitmap is rewritten up to n per transaction
// ---------------------------------------------------------------------------
// goldbach prime pair finder
// microcoded sequencer over a sieve bitmap: builds the sieve of eratosthenes up
// to target, then finds the prime pair p + q = target with the smallest p
// ---------------------------------------------------------------------------
`default_nettype none

`include "goldbach_prime_pair_finder_macros.svh"

module goldbach_prime_pair_finder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire gppf_pkg::field_t target,
	output logic                 done,
	output gppf_pkg::field_t     small_prime,
	output gppf_pkg::field_t     large_prime,
	output logic                 found
);

	import gppf_pkg::*;

	// sequencer
	pc_t    pc_q;
	pc_t    pc_d;
	uword_t uw;
	logic   take;

	// datapath registers
	field_t n_q;
	wide_t  idx_q;     // init sweep address
	wide_t  i_q;       // sieve base
	wide_t  sq_q;      // i_q squared, kept by running sums
	wide_t  m_q;       // multiple being cleared
	wide_t  p_q;       // scan candidate
	logic   rd_a_q;
	logic   rd_b_q;
	field_t small_q;
	field_t large_q;
	logic   found_q;
	logic   done_q;

	// bitmap port signals
	logic   map_mem [MAP_DEPTH];
	logic   we;
	addr_t  waddr;
	logic   wdata;
	logic   re_a;
	logic   re_b;
	addr_t  raddr_a;
	addr_t  raddr_b;

	// condition flags
	wide_t  n_w;
	wide_t  waddr_w;
	logic   c_n_big;
	logic   c_idx_lt_n;
	logic   c_sq_gt_n;
	logic   c_m_le_n;
	logic   c_p_gt_half;

	assign n_w         = wide_t'(n_q);
	assign c_n_big     = n_w > wide_t'(MAX_TARGET);
	assign c_idx_lt_n  = idx_q < n_w;
	assign c_sq_gt_n   = sq_q > n_w;
	assign c_m_le_n    = m_q <= n_w;
	assign c_p_gt_half = p_q > (n_w >> 1);

	// fetch and next-step selection
	always_comb begin
		uw = ucode(pc_q);
		unique case (uw.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_START:   take = !start;
			C_N_BIG:      take = c_n_big;
			C_IDX_LT_N:   take = c_idx_lt_n;
			C_SQ_GT_N:    take = c_sq_gt_n;
			C_NOT_PRIME:  take = !rd_a_q;
			C_M_LE_N:     take = c_m_le_n;
			C_P_GT_HALF:  take = c_p_gt_half;
			C_BOTH_PRIME: take = rd_a_q & rd_b_q;
			default:      take = 1'b1;
		endcase
		pc_d = take ? uw.target : pc_t'(pc_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			pc_q   <= pc_d;
			done_q <= (uw.op == OP_EMIT_HIT) || (uw.op == OP_EMIT_MISS);
		end
	end

	// bitmap access: init sweep sets idx >= 2 and clears the rest, marking clears multiples
	always_comb begin
		we      = (uw.op == OP_INIT_WR) || ((uw.op == OP_MARK) && c_m_le_n);
		waddr_w = (uw.op == OP_INIT_WR) ? idx_q : m_q;
		waddr   = waddr_w[ADDR_W-1:0];
		wdata   = (uw.op == OP_INIT_WR) && (idx_q >= wide_t'(2));
		re_a    = (uw.op == OP_RD_I) || ((uw.op == OP_RD_PAIR) && !c_p_gt_half);
		re_b    = (uw.op == OP_RD_PAIR) && !c_p_gt_half;
		raddr_a = (uw.op == OP_RD_PAIR) ? p_q[ADDR_W-1:0] : i_q[ADDR_W-1:0];
		raddr_b = addr_t'(n_w - p_q);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			map_mem[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= map_mem[raddr_a];
		end
		if (re_b) begin
			rd_b_q <= map_mem[raddr_b];
		end
	end

	// datapath operations, one per step
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_LOAD: begin
				if (start) begin
					n_q   <= target;
					idx_q <= '0;
				end
			end
			OP_INIT_WR: begin
				idx_q <= idx_q + 1'b1;
			end
			OP_SIEVE_SET: begin
				i_q  <= wide_t'(2);
				sq_q <= wide_t'(4);
			end
			OP_M_SET: begin
				m_q <= i_q << 1;
			end
			OP_MARK: begin
				m_q <= m_q + i_q;
			end
			OP_NEXT_I: begin
				// (i+1)^2 = i^2 + 2i + 1
				i_q  <= i_q + 1'b1;
				sq_q <= sq_q + (i_q << 1) + 1'b1;
			end
			OP_SCAN_SET: begin
				p_q <= wide_t'(2);
			end
			OP_P_INC: begin
				p_q <= p_q + 1'b1;
			end
			OP_EMIT_HIT: begin
				small_q <= p_q[FIELD_W-1:0];
				large_q <= field_t'(n_w - p_q);
				found_q <= 1'b1;
			end
			OP_EMIT_MISS: begin
				small_q <= '0;
				large_q <= '0;
				found_q <= 1'b0;
			end
			OP_NOP, OP_RD_I, OP_RD_PAIR: begin
			end
			default: begin
			end
		endcase
	end

	assign busy        = pc_q != ST_IDLE;
	assign done        = done_q;
	assign small_prime = small_q;
	assign large_prime = large_q;
	assign found       = found_q;

	// the result strobe never lasts more than one cycle
	`GPPF_ASSERT_NXT(a_done_pulse, done_q, !done_q, "result strobe held")
	// an accepted transaction moves straight to the range check
	`GPPF_ASSERT_NXT(a_accept_step, start && !busy, pc_q == ST_RANGE, "accept did not advance")
	// a found pair sums to the target
	`GPPF_ASSERT_IMP(a_pair_sum, done_q && found_q,
		(wide_t'(small_q) + wide_t'(large_q)) == n_w, "pair does not sum to target")
	// a miss reports zeros
	`GPPF_ASSERT_IMP(a_miss_zero, done_q && !found_q,
		(small_q == '0) && (large_q == '0), "miss with nonzero primes")
	// the sieve never writes beyond the target
	`GPPF_ASSERT_IMP(a_write_range, we, waddr_w <= n_w, "bitmap write beyond target")

endmodule

`default_nettype wire

// File: tb/goldbach_pair_checker.sv
// ---------------------------------------------------------------------------
// goldbach pair checker
// watches the command and result channels of the prime pair finder, predicts
// each result with its own sieve and compares it field by field
// ---------------------------------------------------------------------------
`default_nettype none

module goldbach_pair_checker
	import gppf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire logic   busy,
	input  wire field_t target,
	input  wire logic   done,
	input  wire field_t small_prime,
	input  wire field_t large_prime,
	input  wire logic   found,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		field_t n;
		field_t small_p;
		field_t large_p;
		logic   hit;
	} prime_pair_t;

	prime_pair_t expected_pairs[$];
	bit          sieve_flags[0:MAX_TARGET];
	int          error_tally = 0;

	// append one prediction behind the older ones
	function automatic void add_expected(input prime_pair_t item);
		expected_pairs.insert(expected_pairs.size(), item);
	endfunction

	// sieve over 0..n, then the first p with p and n-p both prime
	function automatic prime_pair_t goldbach_pair(input field_t n);
		int unsigned lim;
		int unsigned i;
		int unsigned m;
		int unsigned p;
		prime_pair_t r;
		r     = '0;
		r.n   = n;
		lim   = n;
		if (lim > MAX_TARGET)
			return r;
		for (i = 0; i <= lim; i++)
			sieve_flags[i] = (i >= 2);
		for (i = 2; i * i <= lim; i++) begin
			if (sieve_flags[i]) begin
				for (m = 2 * i; m <= lim; m += i)
					sieve_flags[m] = 1'b0;
			end
		end
		for (p = 2; p <= lim / 2; p++) begin
			if (sieve_flags[p] && sieve_flags[lim - p]) begin
				r.small_p = field_t'(p);
				r.large_p = field_t'(lim - p);
				r.hit     = 1'b1;
				break;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		prime_pair_t want;
		if (arst_n) begin
			// result strobe first: it always belongs to an older transaction
			if (done) begin
				if (expected_pairs.size() == 0) begin
					if (error_tally < 10)
						$display("unexpected result p=%0d q=%0d found=%0b",
							small_prime, large_prime, found);
					error_tally++;
				end else begin
					want = expected_pairs.pop_front();
					if (small_prime !== want.small_p || large_prime !== want.large_p ||
							found !== want.hit) begin
						if (error_tally < 10)
							$display("target %0d: expected %0d+%0d found=%0b, got %0d+%0d found=%0b",
								want.n, want.small_p, want.large_p, want.hit,
								small_prime, large_prime, found);
						error_tally++;
					end
				end
			end
			if (start && !busy)
				add_expected(goldbach_pair(target));
		end
		fail_count <= error_tally;
		pending    <= expected_pairs.size();
	end

endmodule

`default_nettype wire

// File: tb/tb_goldbach_prime_pair_finder.sv
// ---------------------------------------------------------------------------
// tb_goldbach_prime_pair_finder
// drives targets into the prime pair finder, first a directed set of edge
// values, then random targets under several sender idle rates; a checker
// beside the block predicts and compares every result
// ---------------------------------------------------------------------------
`default_nettype none

module tb_goldbach_prime_pair_finder;
	import gppf_pkg::*;

	// a full-size target runs long, so the limit leaves a wide margin
	localparam int STALL_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 26;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	field_t target = '0;
	logic   busy;
	logic   done;
	field_t small_prime;
	field_t large_prime;
	logic   found;

	int fail_count;
	int pending;
	int idle_pct    = 0;
	int idle_cycles = 0;

	// edge values: tiny targets with no pair, the first hits, odd hits and
	// misses, the largest target that is decomposed and the ones above it
	int directed_targets[] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 12, 15, 17, 27,
		100, 128, 1000, 65536, 65535, 65537, 131071, 98304};
	int idle_phases[] = '{0, 78, 10};

	always #4 clk = ~clk;

	goldbach_prime_pair_finder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.target      (target),
		.done        (done),
		.small_prime (small_prime),
		.large_prime (large_prime),
		.found       (found)
	);

	goldbach_pair_checker pair_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.target      (target),
		.done        (done),
		.small_prime (small_prime),
		.large_prime (large_prime),
		.found       (found),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// watchdog: any cycle with neither a command nor a result transaction counts
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[goldbach_prime_pair_finder] ERROR");
				$finish;
			end
		end
	end

	// present one target and hold it until the block takes it
	task automatic send_target(input field_t value);
		// random sender gaps, start held low while the roll stays under idle_pct
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		target <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// mostly small targets to keep the sieve short, a few medium ones,
	// and some above the decomposed range that return at once
	function automatic field_t random_target();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return field_t'($urandom_range(1023));
		else if (roll < 86)
			return field_t'($urandom_range(4095, 1024));
		return field_t'($urandom_range(131071, 65537));
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with no gaps
		idle_pct = 0;
		foreach (directed_targets[k])
			send_target(field_t'(directed_targets[k]));

		// random part, one phase per sender idle rate
		foreach (idle_phases[ph]) begin
			idle_pct = idle_phases[ph];
			repeat (RANDOM_ITEMS)
				send_target(random_target());
		end
		start <= 1'b0;

		// the checker count of open transactions is registered, so it lags the accept
		@(posedge clk);
		// drain the outstanding result, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("[goldbach_prime_pair_finder] OK");
		else
			$display("[goldbach_prime_pair_finder] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/gppf_pkg.sv
sv/goldbach_prime_pair_finder.sv
tb/goldbach_pair_checker.sv
tb/tb_goldbach_prime_pair_finder.sv
